FILE: rtl/qbd_pkg.sv
package qbd_pkg;

  localparam logic [1:0] MODE_Q8 = 2'd0;
  localparam logic [1:0] MODE_Q4 = 2'd1;
  localparam logic [1:0] MODE_F16 = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  localparam logic [5:0] Q8_LIMIT = 6'd34;
  localparam logic [5:0] Q4_LIMIT = 6'd18;
  localparam logic [4:0] LAST_INDEX = 5'd31;
  localparam logic [4:0] Q4_HALF = 5'd16;

  typedef struct packed {
    logic [31:0] bits;
    logic [4:0] index;
    logic last_run;
    logic last_block;
  } result_t;

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [31:0] sign;
    logic [4:0] ex;
    logic [9:0] man;
    logic [3:0] k;
    logic [10:0] m;
    begin
      sign = {h[15], 31'd0};
      ex = h[14:10];
      man = h[9:0];
      k = 4'd0;
      m = {1'b0, man};
      if (ex == 5'd0) begin
        if (man == 10'd0) begin
          half_to_single = sign;
        end else begin
          for (int j = 9; j >= 0; j--) begin
            if (man[j] && k == 4'd0) k = 4'(10 - j);
          end
          m = 11'({1'b0, man} << k);
          half_to_single = sign | {1'b0, 8'(8'd113 - 8'(k)), m[9:0], 13'd0};
        end
      end else if (ex == 5'd31) begin
        half_to_single = sign | 32'h7F800000 | {9'd0, man, 13'd0};
      end else begin
        half_to_single = sign | {1'b0, 8'(8'(ex) + 8'd112), man, 13'd0};
      end
    end
  endfunction

endpackage

FILE: rtl/qbd_scale_mul.sv
module qbd_scale_mul
  import qbd_pkg::*;
(
  input  logic [31:0] scale,
  input  logic signed [7:0] q,
  output logic [31:0] product
);

  logic [7:0] mag;
  logic [31:0] qsign;
  logic [23:0] sig;
  logic [31:0] prod;
  logic [8:0] exp_in;
  logic [4:0] lz;
  logic [31:0] norm;
  logic [9:0] exp_out;

  always_comb begin
    mag = q[7] ? 8'(-q) : 8'(q);
    qsign = {q[7], 31'd0};
    exp_in = (scale[30:23] == 8'd0) ? 9'd1 : {1'b0, scale[30:23]};
    sig = {(scale[30:23] != 8'd0), scale[22:0]};
    prod = 32'(sig) * 32'(mag);
    lz = 5'd0;
    for (int j = 31; j >= 0; j--) begin
      if (prod[j] && lz == 5'd0 && !(j == 31)) lz = 5'(31 - j);
    end
    if (prod[31]) lz = 5'd0;
    norm = prod << lz;
    exp_out = 10'(exp_in) + 10'd8 - 10'(lz);
    if ((scale[30:23] == 8'hFF)) begin
      if (scale[22:0] != 23'd0) product = scale | 32'h00400000;
      else if (mag == 8'd0) product = 32'hFFC00000;
      else product = (scale ^ qsign) | 32'h7F800000;
    end else if (mag == 8'd0 || prod == 32'd0) begin
      product = (scale ^ qsign) & 32'h80000000;
    end else if (exp_out[9] || exp_out == 10'd0) begin
      product = ((scale ^ qsign) & 32'h80000000) |
                {9'd0, 23'(32'(prod) >> (10'd1 - exp_out))};
    end else begin
      product = ((scale ^ qsign) & 32'h80000000) | {1'b0, exp_out[7:0], norm[30:8]};
    end
  end

endmodule

FILE: rtl/quantized_block_dequantizer_top.sv
// Quantized block dequantizer.
// The input channel carries one stream byte per transaction with a restart
// flag; the output channel carries one single-precision value per
// transaction with its element index and end markers.
// A transaction happens on a rising edge where valid is high and stall low.
// format_mode is written through cfg_we and cfg_data; the user must do this
// only while the block is idle, as the block itself does not enforce it.
// Scale bytes and the first byte of a half-precision pair give no result.
// Q8_0 and half-precision bytes give one result, Q4_0 data bytes give two,
// each registered in a result register. A byte is accepted in every cycle
// in which the input is not stalled; a Q4_0 data byte keeps the input
// stalled while its second value is produced, until that value is emitted.
// When the receiver stalls, the result register holds and the input side
// stalls for as long as the result register is full and stalled.
// Synchronous reset clears the mode, positions, counters and valid flags.
module quantized_block_dequantizer_top
  import qbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] data_byte,
  input  logic restart,
  output logic out_valid,
  input  logic out_stall,
  output logic [31:0] value_bits,
  output logic [4:0] element_index,
  output logic last_of_run,
  output logic last_of_block
);

  logic [1:0] format_mode;
  logic [5:0] byte_position, byte_position_next;
  logic [15:0] scale_word, scale_word_next;
  logic [7:0] held_low_byte, held_low_byte_next;
  logic [4:0] value_count, value_count_next;
  logic pend, pend_next;
  logic [7:0] pend_byte;
  logic [4:0] pend_index;
  logic out_free, accept, emit;
  logic [5:0] pos, limit;
  result_t res;
  logic [31:0] scale_f, prod;
  logic signed [7:0] q;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = pend || !out_free;
  assign accept = in_valid && !in_stall;
  assign scale_f = half_to_single(scale_word);

  qbd_scale_mul u_mul (.scale(scale_f), .q(q), .product(prod));

  always_comb begin
    byte_position_next = byte_position;
    scale_word_next = scale_word;
    held_low_byte_next = held_low_byte;
    value_count_next = value_count;
    pend_next = pend;
    emit = 1'b0;
    res = '0;
    q = '0;
    pos = restart ? 6'd0 : byte_position;
    limit = (format_mode == MODE_Q8) ? Q8_LIMIT : Q4_LIMIT;
    if (pend) begin
      q = 8'(pend_byte[7:4]) - 8'sd8;
      if (out_free) begin
        emit = 1'b1;
        pend_next = 1'b0;
        res = '{bits: prod, index: pend_index, last_run: 1'b1,
                last_block: (pend_index == LAST_INDEX)};
      end
    end else if (accept && format_mode != MODE_NONE) begin
      if (format_mode == MODE_F16) begin
        if (pos != 6'd1) begin
          held_low_byte_next = data_byte;
          byte_position_next = 6'd1;
        end else begin
          byte_position_next = 6'd0;
          emit = 1'b1;
          res = '{bits: half_to_single({data_byte, held_low_byte}),
                  index: value_count, last_run: 1'b1,
                  last_block: (value_count == LAST_INDEX)};
          value_count_next = value_count + 5'd1;
        end
      end else begin
        if (pos >= limit) pos = 6'd0;
        if (pos == 6'd0) begin
          scale_word_next = {scale_word[15:8], data_byte};
          byte_position_next = 6'd1;
        end else if (pos == 6'd1) begin
          scale_word_next = {data_byte, scale_word[7:0]};
          byte_position_next = 6'd2;
        end else begin
          byte_position_next = (pos + 6'd1 >= limit) ? 6'd0 : pos + 6'd1;
          emit = 1'b1;
          if (format_mode == MODE_Q8) begin
            q = data_byte;
            res = '{bits: prod, index: 5'(pos - 6'd2), last_run: 1'b1,
                    last_block: (5'(pos - 6'd2) == LAST_INDEX)};
          end else begin
            q = 8'(data_byte[3:0]) - 8'sd8;
            pend_next = 1'b1;
            res = '{bits: prod, index: 5'(pos - 6'd2), last_run: 1'b0,
                    last_block: 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= MODE_Q8;
      byte_position <= '0;
      scale_word <= '0;
      held_low_byte <= '0;
      value_count <= '0;
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= pend_next;
      scale_word <= scale_word_next;
      held_low_byte <= held_low_byte_next;
      if (cfg_we) begin
        format_mode <= cfg_data;
        byte_position <= '0;
        value_count <= '0;
      end else begin
        byte_position <= byte_position_next;
        value_count <= value_count_next;
      end
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_bits <= res.bits;
      element_index <= res.index;
      last_of_run <= res.last_run;
      last_of_block <= res.last_block;
    end
    if (!pend) begin
      pend_byte <= data_byte;
      pend_index <= 5'(pos - 6'd2) + Q4_HALF;
    end
  end

endmodule
